FILE: design/clr_pkg.sv
// Package for the clipped line rasterizer: layer dimension widths, the control
// register map, the opcode codes and the step direction codes.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

   // Layer width and height registers are 12 bits. Addresses are 32 bits wide.
   localparam int DIM_WIDTH      = 12;
   localparam int ADDR_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // Control register indexes, taken from csr_paddr[3:2].
   localparam logic [1:0] REG_LAYER_WIDTH  = 2'd0;
   localparam logic [1:0] REG_LAYER_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BUFFER_BASE  = 2'd2;

   localparam logic [DIM_WIDTH-1:0] LAYER_WIDTH_RESET  = 12'd1024;
   localparam logic [DIM_WIDTH-1:0] LAYER_HEIGHT_RESET = 12'd768;

   // Opcodes, carried on req_tuser.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Step direction of one axis, as a two-bit signed value.
   typedef logic [1:0] dir_type;
   localparam dir_type DIR_NONE = 2'b00;
   localparam dir_type DIR_POS  = 2'b01;
   localparam dir_type DIR_NEG  = 2'b11;

endpackage

`default_nettype wire

FILE: design/clipped_line_rasterizer.sv
// Clipped line rasterizer: integer DDA line walker with layer clipping and
// pixel address generation. Depends on clr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Word contents
// req_     in         tuser: opcode; tdata: x_start, y_start, x_end, y_end, line_color
// rsp_     out        tuser: in_bounds; tdata: pixel_address, pixel_color; tlast: last_pixel
// csr_     in/out     APB: layer_width, layer_height, buffer_base at 0x0, 0x4, 0x8
//
// One word is taken per cycle while the result register does not stall. A step word sits in
// the input register while the address multiply-add feeds the result register, so
// rsp_tvalid rises once the word has passed the input register and the result register.
// A start word, or a step word with no line active, gives no pixel.
// reset clears the line state and loads the register defaults.
// While the result register stalls, the input register still takes words until it holds a step word for an active line.
module clipped_line_rasterizer #(
   parameter int COORD_WIDTH = 12,
   parameter int COLOR_WIDTH = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // req_tdata from bit 0: x_start, y_start, x_end, y_end, line_color, zero fill
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [((4*COORD_WIDTH+COLOR_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_tuser: opcode
   input  wire                                    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // rsp_tdata from bit 0: pixel_address, pixel_color, zero fill
   output logic [((clr_pkg::ADDR_WIDTH+COLOR_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: in_bounds
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [clr_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire  [clr_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [clr_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW       = COORD_WIDTH;
   localparam int DW       = clr_pkg::DIM_WIDTH;
   localparam int AW       = clr_pkg::ADDR_WIDTH;
   localparam int RSP_W    = ((AW + COLOR_WIDTH + 7) / 8) * 8;
   localparam int CMP_W    = (CW - 1 > DW) ? CW - 1 : DW;
   localparam int PROD_W   = CW - 1 + DW;

   // ---------------- control registers ----------------
   logic [DW-1:0] layer_width_ff, layer_width_in;
   logic [DW-1:0] layer_height_ff, layer_height_in;
   logic [AW-1:0] buffer_base_ff, buffer_base_in;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      layer_width_in  = layer_width_ff;
      layer_height_in = layer_height_ff;
      buffer_base_in  = buffer_base_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            clr_pkg::REG_LAYER_WIDTH:  layer_width_in  = csr_pwdata[DW-1:0];
            clr_pkg::REG_LAYER_HEIGHT: layer_height_in = csr_pwdata[DW-1:0];
            clr_pkg::REG_BUFFER_BASE:  buffer_base_in  = csr_pwdata[AW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         clr_pkg::REG_LAYER_WIDTH:  csr_prdata = 32'(layer_width_ff);
         clr_pkg::REG_LAYER_HEIGHT: csr_prdata = 32'(layer_height_ff);
         clr_pkg::REG_BUFFER_BASE:  csr_prdata = 32'(buffer_base_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_width_ff  <= clr_pkg::LAYER_WIDTH_RESET;
         layer_height_ff <= clr_pkg::LAYER_HEIGHT_RESET;
         buffer_base_ff  <= '0;
      end else begin
         layer_width_ff  <= layer_width_in;
         layer_height_ff <= layer_height_in;
         buffer_base_ff  <= buffer_base_in;
      end
   end

   // ---------------- input register ----------------
   logic                          in_valid_ff, in_valid_in;
   logic                          in_op_ff;
   logic signed [CW-1:0]          in_xs_ff, in_ys_ff, in_xe_ff, in_ye_ff;
   logic [COLOR_WIDTH-1:0]        in_color_ff;
   logic                          req_take;

   // ---------------- line state ----------------
   logic signed [CW-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW:0]            err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic [CW-1:0]          abs_dx_ff, abs_dx_in, abs_dy_ff, abs_dy_in;
   logic [CW-1:0]          major_ff, major_in;
   clr_pkg::dir_type       dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [CW:0]            pixels_left_ff, pixels_left_in;
   logic [COLOR_WIDTH-1:0] held_color_ff, held_color_in;
   logic                   active_ff, active_in;

   // ---------------- result register ----------------
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]          rsp_addr_ff, rsp_addr_in;
   logic [COLOR_WIDTH-1:0] rsp_color_ff;
   logic                   rsp_inb_ff, rsp_inb_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic produces, advance, do_start, do_step;

   assign produces   = (in_op_ff == clr_pkg::OP_STEP) && active_ff;
   assign advance    = in_valid_ff && (!produces || !rsp_valid_ff || rsp_tready);
   assign do_start   = advance && (in_op_ff == clr_pkg::OP_START);
   assign do_step    = advance && produces;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= req_tuser;
         in_xs_ff    <= req_tdata[CW-1:0];
         in_ys_ff    <= req_tdata[2*CW-1:CW];
         in_xe_ff    <= req_tdata[3*CW-1:2*CW];
         in_ye_ff    <= req_tdata[4*CW-1:3*CW];
         in_color_ff <= req_tdata[4*CW+COLOR_WIDTH-1:4*CW];
      end
   end

   // ---------------- line setup ----------------
   logic signed [CW:0] dx, dy, neg_dx, neg_dy;
   logic [CW-1:0]      mag_x, mag_y;
   clr_pkg::dir_type   sdir_x, sdir_y;

   assign dx     = {in_xe_ff[CW-1], in_xe_ff} - {in_xs_ff[CW-1], in_xs_ff};
   assign dy     = {in_ye_ff[CW-1], in_ye_ff} - {in_ys_ff[CW-1], in_ys_ff};
   assign neg_dx = -dx;
   assign neg_dy = -dy;
   assign mag_x  = dx[CW] ? neg_dx[CW-1:0] : dx[CW-1:0];
   assign mag_y  = dy[CW] ? neg_dy[CW-1:0] : dy[CW-1:0];
   assign sdir_x = dx[CW] ? clr_pkg::DIR_NEG :
                   (dx == '0) ? clr_pkg::DIR_NONE : clr_pkg::DIR_POS;
   assign sdir_y = dy[CW] ? clr_pkg::DIR_NEG :
                   (dy == '0) ? clr_pkg::DIR_NONE : clr_pkg::DIR_POS;

   // ---------------- pixel and DDA advance ----------------
   logic                 x_nonneg, y_nonneg, inb, last;
   logic [CW-2:0]        x_mag, y_mag;
   logic [PROD_W-1:0]    row_offset;
   logic [CW:0]          sum_x, sum_y;
   logic                 move_x, move_y;

   assign x_nonneg   = !cur_x_ff[CW-1];
   assign y_nonneg   = !cur_y_ff[CW-1];
   assign x_mag      = cur_x_ff[CW-2:0];
   assign y_mag      = cur_y_ff[CW-2:0];
   assign inb        = x_nonneg && y_nonneg
                       && (CMP_W'(x_mag) < CMP_W'(layer_width_ff))
                       && (CMP_W'(y_mag) < CMP_W'(layer_height_ff));
   assign row_offset = PROD_W'(y_mag) * PROD_W'(layer_width_ff);
   assign last       = pixels_left_ff <= (CW+1)'(1);

   // The error never exceeds the major length, so the sum fits one extra bit.
   assign sum_x  = err_x_ff + {1'b0, abs_dx_ff};
   assign sum_y  = err_y_ff + {1'b0, abs_dy_ff};
   assign move_x = sum_x >= {1'b0, major_ff};
   assign move_y = sum_y >= {1'b0, major_ff};

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      err_x_in       = err_x_ff;
      err_y_in       = err_y_ff;
      abs_dx_in      = abs_dx_ff;
      abs_dy_in      = abs_dy_ff;
      major_in       = major_ff;
      dir_x_in       = dir_x_ff;
      dir_y_in       = dir_y_ff;
      pixels_left_in = pixels_left_ff;
      held_color_in  = held_color_ff;
      active_in      = active_ff;
      if (do_start) begin
         cur_x_in       = in_xs_ff;
         cur_y_in       = in_ys_ff;
         err_x_in       = '0;
         err_y_in       = '0;
         abs_dx_in      = mag_x;
         abs_dy_in      = mag_y;
         major_in       = (mag_x > mag_y) ? mag_x : mag_y;
         dir_x_in       = sdir_x;
         dir_y_in       = sdir_y;
         pixels_left_in = {1'b0, major_in} + (CW+1)'(1);
         held_color_in  = in_color_ff;
         active_in      = 1'b1;
      end else if (do_step) begin
         if (last) begin
            pixels_left_in = '0;
            active_in      = 1'b0;
         end else begin
            pixels_left_in = pixels_left_ff - (CW+1)'(1);
         end
         if (move_x) begin
            err_x_in = sum_x - {1'b0, major_ff};
            cur_x_in = cur_x_ff + {{(CW-2){dir_x_ff[1]}}, dir_x_ff};
         end else begin
            err_x_in = sum_x;
         end
         if (move_y) begin
            err_y_in = sum_y - {1'b0, major_ff};
            cur_y_in = cur_y_ff + {{(CW-2){dir_y_ff[1]}}, dir_y_ff};
         end else begin
            err_y_in = sum_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         err_x_ff       <= '0;
         err_y_ff       <= '0;
         abs_dx_ff      <= '0;
         abs_dy_ff      <= '0;
         major_ff       <= '0;
         dir_x_ff       <= clr_pkg::DIR_NONE;
         dir_y_ff       <= clr_pkg::DIR_NONE;
         pixels_left_ff <= '0;
         held_color_ff  <= '0;
         active_ff      <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         err_x_ff       <= err_x_in;
         err_y_ff       <= err_y_in;
         abs_dx_ff      <= abs_dx_in;
         abs_dy_ff      <= abs_dy_in;
         major_ff       <= major_in;
         dir_x_ff       <= dir_x_in;
         dir_y_ff       <= dir_y_in;
         pixels_left_ff <= pixels_left_in;
         held_color_ff  <= held_color_in;
         active_ff      <= active_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_addr_in = inb ? (buffer_base_ff + AW'(row_offset) + AW'(x_mag)) : '0;
   assign rsp_inb_in  = inb;
   assign rsp_last_in = last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_step) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_color_ff <= held_color_ff;
         rsp_inb_ff   <= rsp_inb_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_color_ff, rsp_addr_ff});
   assign rsp_tuser  = rsp_inb_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   a_active_has_pixels : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (pixels_left_ff != '0))
      else $error("active line with no pixels left");

   a_err_bounded : assert property (@(posedge clock) disable iff (reset)
      (err_x_ff < {1'b0, major_ff} || err_x_ff == '0)
      && (err_y_ff < {1'b0, major_ff} || err_y_ff == '0))
      else $error("DDA error accumulator out of range");

   a_major_covers : assert property (@(posedge clock) disable iff (reset)
      (major_ff >= abs_dx_ff) && (major_ff >= abs_dy_ff))
      else $error("major length below an axis length");

   a_result_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(do_step))
      else $error("result appeared without a step word");

endmodule

`default_nettype wire
